/* hw/rtl/preemptive_priority_scheduler_core_macros.svh */
// assertion macros for the scheduler checker
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_CORE_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define PPSCH_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define PPSCH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/ppsch_pkg.sv */
// ----------------------------------------------------------------------------
// ppsch_pkg
// Shared types and codes of the preemptive priority scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package ppsch_pkg;

   localparam int SLOTS_DEF = 16;

   localparam int TIME_W  = 32;
   localparam int TASK_W  = 8;
   localparam int BURST_W = 16;
   localparam int PRIO_W  = 8;
   localparam int KIND_W  = 2;

   localparam logic OP_TICK   = 1'b0;
   localparam logic OP_ARRIVE = 1'b1;

   localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT,
      ST_RESP
   } state_type;

   // best candidate handed from cell to cell
   typedef struct packed {
      logic               vld;
      logic [PRIO_W-1:0]  prio;
      logic [TIME_W-1:0]  age;
      logic [BURST_W-1:0] burst;
      logic [BURST_W-1:0] left;
      logic [TASK_W-1:0]  task_id;
   } cand_type;

   // update broadcast to all cells
   typedef struct packed {
      logic               arrive;
      logic               dec;
      logic [TASK_W-1:0]  task_id;
      logic [PRIO_W-1:0]  prio;
      logic [BURST_W-1:0] burst;
   } cmd_type;

endpackage

`default_nettype wire

/* hw/rtl/ppsch_cell.sv */
// ----------------------------------------------------------------------------
// ppsch_cell
// One task slot; merges its entry into the running best candidate and
// lowest free slot passed along the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module ppsch_cell #(
   parameter int SLOTS = ppsch_pkg::SLOTS_DEF,
   parameter int IDX   = 0
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire  [ppsch_pkg::TIME_W-1:0]     now_i,
   input  ppsch_pkg::cand_type              cand_i,
   input  wire  [$clog2(SLOTS)-1:0]         best_idx_i,
   input  wire                              free_found_i,
   input  wire  [$clog2(SLOTS)-1:0]         free_idx_i,
   input  ppsch_pkg::cmd_type               cmd_i,
   input  wire  [$clog2(SLOTS)-1:0]         tgt_idx_i,
   output ppsch_pkg::cand_type              cand_o,
   output logic [$clog2(SLOTS)-1:0]         best_idx_o,
   output logic                             free_found_o,
   output logic [$clog2(SLOTS)-1:0]         free_idx_o
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

   logic                              valid_ff, valid_in;
   logic [ppsch_pkg::TASK_W-1:0]      task_ff, task_in;
   logic [ppsch_pkg::PRIO_W-1:0]      prio_ff, prio_in;
   logic [ppsch_pkg::BURST_W-1:0]     left_ff, left_in;
   logic [ppsch_pkg::BURST_W-1:0]     burst_ff, burst_in;
   logic [ppsch_pkg::TIME_W-1:0]      arrival_ff, arrival_in;

   ppsch_pkg::cand_type               cand_ff, cand_in;
   logic [IDX_W-1:0]                  best_idx_ff, best_idx_in;
   logic                              free_found_ff, free_found_in;
   logic [IDX_W-1:0]                  free_idx_ff, free_idx_in;

   logic [ppsch_pkg::TIME_W-1:0]      own_age;
   logic                              hit;
   logic                              beat;

   assign hit = (tgt_idx_i == MY_IDX);

   // slot update
   always_comb begin
      valid_in   = valid_ff;
      task_in    = task_ff;
      prio_in    = prio_ff;
      left_in    = left_ff;
      burst_in   = burst_ff;
      arrival_in = arrival_ff;
      if (cmd_i.arrive && hit) begin
         valid_in   = 1'b1;
         task_in    = cmd_i.task_id;
         prio_in    = cmd_i.prio;
         left_in    = cmd_i.burst;
         burst_in   = cmd_i.burst;
         arrival_in = now_i;
      end else if (cmd_i.dec && hit) begin
         left_in = left_ff - ppsch_pkg::BURST_W'(1);
         if (left_ff == ppsch_pkg::BURST_W'(1)) begin
            valid_in = 1'b0;
         end
      end
   end

   // candidate merge
   always_comb begin
      own_age = now_i - arrival_ff;
      beat    = 1'b0;
      if (valid_ff) begin
         if (!cand_i.vld) begin
            beat = 1'b1;
         end else if (prio_ff != cand_i.prio) begin
            beat = (prio_ff < cand_i.prio);
         end else if (own_age != cand_i.age) begin
            beat = (own_age > cand_i.age);
         end else begin
            beat = (burst_ff < cand_i.burst);
         end
      end

      if (beat) begin
         cand_in.vld     = 1'b1;
         cand_in.prio    = prio_ff;
         cand_in.age     = own_age;
         cand_in.burst   = burst_ff;
         cand_in.left    = left_ff;
         cand_in.task_id = task_ff;
         best_idx_in     = MY_IDX;
      end else begin
         cand_in     = cand_i;
         best_idx_in = best_idx_i;
      end

      free_found_in = free_found_i | ~valid_ff;
      free_idx_in   = free_found_i ? free_idx_i : MY_IDX;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         cand_ff       <= '0;
         free_found_ff <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         cand_ff       <= cand_in;
         free_found_ff <= free_found_in;
      end
   end

   always_ff @(posedge clock) begin
      task_ff     <= task_in;
      prio_ff     <= prio_in;
      left_ff     <= left_in;
      burst_ff    <= burst_in;
      arrival_ff  <= arrival_in;
      best_idx_ff <= best_idx_in;
      free_idx_ff <= free_idx_in;
   end

   assign cand_o       = cand_ff;
   assign best_idx_o   = best_idx_ff;
   assign free_found_o = free_found_ff;
   assign free_idx_o   = free_idx_ff;

endmodule

`default_nettype wire

/* hw/rtl/preemptive_priority_scheduler_core.sv */
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_core
// Tick-driven preemptive priority scheduler built on a chain of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one word per event. req_op = 0 is a time tick, req_op = 1
//   is a task arrival carrying req_task_id, req_burst and req_prio.
//   rsp channel: exactly one word per request word, in order.
//   Each request walks the row of SLOTS cells: every cycle each cell merges
//   its slot into the best candidate and lowest free slot from its left
//   neighbor, so the result reaches the end of the row through the register
//   of every cell. A request passes through the SCAN, COMMIT and RESP states
//   before its word enters the rsp output register; a new request is taken
//   only once the controller is back in IDLE.
//   Reset empties all slots and sets the time counter to zero.
//   A pending rsp word is held stable until rsp_ready; the next request may
//   be accepted and scanned meanwhile, and waits for the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module preemptive_priority_scheduler_core #(
   parameter int SLOTS = ppsch_pkg::SLOTS_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire                               req_op,
   input  wire  [ppsch_pkg::TASK_W-1:0]      req_task_id,
   input  wire  [ppsch_pkg::BURST_W-1:0]     req_burst,
   input  wire  [ppsch_pkg::PRIO_W-1:0]      req_prio,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic [ppsch_pkg::KIND_W-1:0]      rsp_kind,
   output logic [ppsch_pkg::TIME_W-1:0]      rsp_now,
   output logic [ppsch_pkg::TASK_W-1:0]      rsp_ran_id,
   output logic                              rsp_idle,
   output logic                              rsp_finished,
   output logic [ppsch_pkg::TIME_W-1:0]      rsp_turnaround,
   output logic [ppsch_pkg::TIME_W-1:0]      rsp_waiting
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int TW    = ppsch_pkg::TIME_W;
   localparam int BW    = ppsch_pkg::BURST_W;

   ppsch_pkg::state_type              state_ff, state_in;
   logic [IDX_W-1:0]                  cnt_ff, cnt_in;
   logic                              op_ff, op_in;
   logic [ppsch_pkg::TASK_W-1:0]      task_ff, task_in;
   logic [BW-1:0]                     burst_ff, burst_in;
   logic [ppsch_pkg::PRIO_W-1:0]      prio_ff, prio_in;
   logic [TW-1:0]                     now_ff, now_in;
   logic [ppsch_pkg::KIND_W-1:0]      kind_ff, kind_in;
   logic [ppsch_pkg::TASK_W-1:0]      ran_ff, ran_in;
   logic                              idle_ff, idle_in;
   logic                              fin_ff, fin_in;
   logic [TW-1:0]                     tat_ff, tat_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [ppsch_pkg::KIND_W-1:0]      rsp_kind_ff, rsp_kind_in;
   logic [TW-1:0]                     rsp_now_ff, rsp_now_in;
   logic [ppsch_pkg::TASK_W-1:0]      rsp_ran_ff, rsp_ran_in;
   logic                              rsp_idle_ff, rsp_idle_in;
   logic                              rsp_fin_ff, rsp_fin_in;
   logic [TW-1:0]                     rsp_tat_ff, rsp_tat_in;
   logic [TW-1:0]                     rsp_wait_ff, rsp_wait_in;

   ppsch_pkg::cmd_type                cmd;
   logic [IDX_W-1:0]                  tgt_idx;

   ppsch_pkg::cand_type               cand_w     [SLOTS+1];
   logic [IDX_W-1:0]                  best_idx_w [SLOTS+1];
   logic                              found_w    [SLOTS+1];
   logic [IDX_W-1:0]                  free_idx_w [SLOTS+1];

   assign cand_w[0]     = '0;
   assign best_idx_w[0] = '0;
   assign found_w[0]    = 1'b0;
   assign free_idx_w[0] = '0;

   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      ppsch_cell #(
         .SLOTS(SLOTS),
         .IDX  (g)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .now_i       (now_ff),
         .cand_i      (cand_w[g]),
         .best_idx_i  (best_idx_w[g]),
         .free_found_i(found_w[g]),
         .free_idx_i  (free_idx_w[g]),
         .cmd_i       (cmd),
         .tgt_idx_i   (tgt_idx),
         .cand_o      (cand_w[g+1]),
         .best_idx_o  (best_idx_w[g+1]),
         .free_found_o(found_w[g+1]),
         .free_idx_o  (free_idx_w[g+1])
      );
   end

   assign req_ready = (state_ff == ppsch_pkg::ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      op_in        = op_ff;
      task_in      = task_ff;
      burst_in     = burst_ff;
      prio_in      = prio_ff;
      now_in       = now_ff;
      kind_in      = kind_ff;
      ran_in       = ran_ff;
      idle_in      = idle_ff;
      fin_in       = fin_ff;
      tat_in       = tat_ff;

      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_now_in   = rsp_now_ff;
      rsp_ran_in   = rsp_ran_ff;
      rsp_idle_in  = rsp_idle_ff;
      rsp_fin_in   = rsp_fin_ff;
      rsp_tat_in   = rsp_tat_ff;
      rsp_wait_in  = rsp_wait_ff;

      cmd          = '0;
      cmd.task_id  = task_ff;
      cmd.prio     = prio_ff;
      cmd.burst    = burst_ff;
      tgt_idx      = '0;

      unique case (state_ff)
         ppsch_pkg::ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_op;
               task_in  = req_task_id;
               prio_in  = req_prio;
               burst_in = (req_burst == '0) ? BW'(1) : req_burst;
               cnt_in   = '0;
               state_in = ppsch_pkg::ST_SCAN;
            end
         end
         ppsch_pkg::ST_SCAN: begin
            if (cnt_ff == IDX_W'(SLOTS - 1)) begin
               state_in = ppsch_pkg::ST_COMMIT;
            end else begin
               cnt_in = cnt_ff + IDX_W'(1);
            end
         end
         ppsch_pkg::ST_COMMIT: begin
            idle_in = 1'b0;
            fin_in  = 1'b0;
            tat_in  = '0;
            if (op_ff == ppsch_pkg::OP_ARRIVE) begin
               ran_in = task_ff;
               if (found_w[SLOTS]) begin
                  cmd.arrive = 1'b1;
                  tgt_idx    = free_idx_w[SLOTS];
                  kind_in    = ppsch_pkg::KIND_ACCEPT;
               end else begin
                  kind_in = ppsch_pkg::KIND_REJECT;
               end
            end else begin
               kind_in = ppsch_pkg::KIND_TICK;
               now_in  = now_ff + TW'(1);
               if (cand_w[SLOTS].vld) begin
                  cmd.dec  = 1'b1;
                  tgt_idx  = best_idx_w[SLOTS];
                  ran_in   = cand_w[SLOTS].task_id;
                  burst_in = cand_w[SLOTS].burst;
                  if (cand_w[SLOTS].left == BW'(1)) begin
                     fin_in = 1'b1;
                     tat_in = cand_w[SLOTS].age + TW'(1);
                  end
               end else begin
                  ran_in  = '0;
                  idle_in = 1'b1;
               end
            end
            state_in = ppsch_pkg::ST_RESP;
         end
         ppsch_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = kind_ff;
               rsp_now_in   = now_ff;
               rsp_ran_in   = ran_ff;
               rsp_idle_in  = idle_ff;
               rsp_fin_in   = fin_ff;
               rsp_tat_in   = tat_ff;
               rsp_wait_in  = fin_ff ? (tat_ff - {{(TW - BW){1'b0}}, burst_ff}) : '0;
               state_in     = ppsch_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ppsch_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ppsch_pkg::ST_IDLE;
         now_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      op_ff       <= op_in;
      task_ff     <= task_in;
      burst_ff    <= burst_in;
      prio_ff     <= prio_in;
      kind_ff     <= kind_in;
      ran_ff      <= ran_in;
      idle_ff     <= idle_in;
      fin_ff      <= fin_in;
      tat_ff      <= tat_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_now_ff  <= rsp_now_in;
      rsp_ran_ff  <= rsp_ran_in;
      rsp_idle_ff <= rsp_idle_in;
      rsp_fin_ff  <= rsp_fin_in;
      rsp_tat_ff  <= rsp_tat_in;
      rsp_wait_ff <= rsp_wait_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_now        = rsp_now_ff;
   assign rsp_ran_id     = rsp_ran_ff;
   assign rsp_idle       = rsp_idle_ff;
   assign rsp_finished   = rsp_fin_ff;
   assign rsp_turnaround = rsp_tat_ff;
   assign rsp_waiting    = rsp_wait_ff;

endmodule

`default_nettype wire

/* hw/rtl/ppsch_checker.sv */
// ----------------------------------------------------------------------------
// ppsch_checker
// Port-level checks on the scheduler's result words, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "preemptive_priority_scheduler_core_macros.svh"

module ppsch_checker (
   input wire                              clock,
   input wire                              reset,
   input wire                              rsp_valid,
   input wire                              rsp_ready,
   input wire [ppsch_pkg::KIND_W-1:0]      rsp_kind,
   input wire [ppsch_pkg::TIME_W-1:0]      rsp_now,
   input wire [ppsch_pkg::TASK_W-1:0]      rsp_ran_id,
   input wire                              rsp_idle,
   input wire                              rsp_finished,
   input wire [ppsch_pkg::TIME_W-1:0]      rsp_turnaround,
   input wire [ppsch_pkg::TIME_W-1:0]      rsp_waiting
);

   // idle tick reports nothing else
   `PPSCH_ASSERT_NOW(a_idle_clean, clock, reset,
      rsp_valid && rsp_idle,
      rsp_kind == ppsch_pkg::KIND_TICK && !rsp_finished && rsp_ran_id == '0,
      "idle tick word carries task data")

   // times only on completion
   `PPSCH_ASSERT_NOW(a_times_zero, clock, reset,
      rsp_valid && !rsp_finished,
      rsp_turnaround == '0 && rsp_waiting == '0,
      "turnaround or waiting set without completion")

   // arrival words never report idle or completion
   `PPSCH_ASSERT_NOW(a_arrival_flags, clock, reset,
      rsp_valid && rsp_kind != ppsch_pkg::KIND_TICK,
      !rsp_idle && !rsp_finished,
      "arrival word carries tick flags")

   // stalled word holds
   `PPSCH_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_now) && $stable(rsp_kind) && $stable(rsp_ran_id),
      "stalled result word changed")

endmodule

bind preemptive_priority_scheduler_core ppsch_checker u_ppsch_checker (.*);

`default_nettype wire
